// ----- rtl/wildcard_signature_scanner_defines.svh -----
// ----------------------------------------------------------------------------
// Wildcard signature scanner assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_SIGNATURE_SCANNER_DEFINES_SVH
`define WILDCARD_SIGNATURE_SCANNER_DEFINES_SVH

// same-cycle implication
`define WSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wss assertion failed");

// next-cycle implication
`define WSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wss assertion failed");

`endif

// ----- rtl/wss_pkg.sv -----
// ----------------------------------------------------------------------------
// Wildcard signature scanner package
// Sizes, codes, cell control bundle and hex helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wss_pkg;

  localparam int PAT_DEPTH = 128;
  localparam int IDX_W     = $clog2(PAT_DEPTH);
  localparam int LEN_W     = $clog2(PAT_DEPTH + 1);
  localparam int OFF_W     = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_SIG    = 2'd1,
    ACT_REGION = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_SINGLE  = 3'd2,
    ST_BADHEX  = 3'd3,
    ST_TOOLONG = 3'd4,
    ST_MATCH   = 3'd5,
    ST_NOMATCH = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PH_COLLECT = 3'b001,
    PH_SEARCH  = 3'b010,
    PH_HALT    = 3'b100
  } phase_t;

  typedef struct packed {
    logic       app;      // append an entry at the write index
    logic [7:0] wr_byte;
    logic       wr_wild;
    logic       pm_clr;   // clear partial-match bits
    logic       step;     // advance partial matches by one region byte
    logic [7:0] rbyte;
  } cell_ctl_t;

  function automatic logic [7:0] up_case(input logic [7:0] c);
    up_case = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    logic [7:0] u;
    u = up_case(c);
    is_hex = (u >= 8'h30 && u <= 8'h39) || (u >= 8'h41 && u <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] v;
    u = up_case(c);
    v = (u >= 8'h30 && u <= 8'h39) ? u - 8'd48 : u - 8'd55;
    hex_val = v[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wss_cell.sv -----
// ----------------------------------------------------------------------------
// Wildcard signature scanner cell
// One pattern position: byte, wildcard flag, tail flag and partial-match bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wss_cell
  import wss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire logic      sel,
  input  wire logic      prev_i,
  output logic           pm_o,
  output logic           hit_o
);

  logic [7:0] byte_r;
  logic       wild_r;
  logic       tail_r;
  logic       pm_r;
  logic       pm_nxt;

  assign pm_nxt = prev_i && (wild_r || byte_r == ctl.rbyte);
  assign pm_o   = pm_r;
  assign hit_o  = tail_r && pm_nxt;

  always_ff @(posedge clk) begin
    if (ctl.app && sel) begin
      byte_r <= ctl.wr_byte;
      wild_r <= ctl.wr_wild;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r <= 1'b0;
      pm_r   <= 1'b0;
    end else begin
      if (ctl.app) begin
        tail_r <= sel;
      end
      if (ctl.pm_clr) begin
        pm_r <= 1'b0;
      end else if (ctl.step) begin
        pm_r <= pm_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wss_ctrl.sv -----
// ----------------------------------------------------------------------------
// Wildcard signature scanner control
// Signature parser, search bookkeeping and per-request status/offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wss_ctrl
  import wss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire_i,
  input  wire logic [1:0]       action_i,
  input  wire logic [7:0]       data_i,
  input  wire logic             last_i,
  input  wire logic             any_hit_i,
  output cell_ctl_t             ctl_o,
  output logic [IDX_W-1:0]      wr_idx_o,
  output status_t               status_o,
  output logic [OFF_W-1:0]      offset_o
);

  phase_t             phase_r, phase_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [IDX_W-1:0]   span_r, span_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic               wait_r, wait_nxt;
  logic [OFF_W-1:0]   roff_r, roff_nxt;
  logic               seen_r, seen_nxt;

  logic               do_app;
  logic [7:0]         app_byte;
  logic               app_wild;
  logic               matched;

  assign wr_idx_o = len_r[IDX_W-1:0];

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    span_nxt  = span_r;
    pend_nxt  = pend_r;
    wait_nxt  = wait_r;
    roff_nxt  = roff_r;
    seen_nxt  = seen_r;
    ctl_o       = '0;
    ctl_o.rbyte = data_i;
    status_o  = ST_NONE;
    offset_o  = '0;
    do_app    = 1'b0;
    app_byte  = 8'h00;
    app_wild  = 1'b0;
    matched   = 1'b0;

    if (fire_i) begin
      priority if (action_i == ACT_CLEAR) begin
        phase_nxt    = PH_COLLECT;
        len_nxt      = '0;
        span_nxt     = '0;
        pend_nxt     = 8'h00;
        wait_nxt     = 1'b0;
        roff_nxt     = '0;
        seen_nxt     = 1'b0;
        ctl_o.pm_clr = 1'b1;
      end else if (action_i == ACT_SIG && phase_r == PH_COLLECT) begin
        if (wait_r) begin
          if (data_i == CH_NUL || data_i == CH_QMARK || data_i == CH_SPACE) begin
            phase_nxt = PH_HALT;
            wait_nxt  = 1'b0;
            status_o  = ST_SINGLE;
          end else if (!is_hex(pend_r) || !is_hex(data_i)) begin
            phase_nxt = PH_HALT;
            wait_nxt  = 1'b0;
            status_o  = ST_BADHEX;
          end else begin
            wait_nxt = 1'b0;
            do_app   = 1'b1;
            app_byte = {hex_val(pend_r), hex_val(data_i)};
          end
        end else if (data_i == CH_SPACE) begin
          status_o = ST_NONE;
        end else if (data_i == CH_NUL) begin
          phase_nxt    = PH_SEARCH;
          roff_nxt     = '0;
          seen_nxt     = 1'b0;
          ctl_o.pm_clr = 1'b1;
          status_o     = ST_ACCEPT;
        end else if (data_i == CH_QMARK) begin
          do_app   = 1'b1;
          app_wild = 1'b1;
        end else begin
          pend_nxt = data_i;
          wait_nxt = 1'b1;
        end
      end else if (action_i == ACT_REGION && phase_r == PH_SEARCH) begin
        if (!seen_r) begin
          ctl_o.step = 1'b1;
          matched    = (len_r == '0) || any_hit_i;
          if (matched) begin
            seen_nxt = 1'b1;
            status_o = ST_MATCH;
            offset_o = roff_r - OFF_W'(span_r);
          end
        end
        roff_nxt = roff_r + OFF_W'(1);
        if (last_i) begin
          phase_nxt = PH_HALT;
          if (!seen_r && !matched) begin
            status_o = ST_NOMATCH;
          end
        end
      end else begin
        status_o = ST_NONE;
      end
    end

    if (do_app) begin
      ctl_o.app     = 1'b1;
      ctl_o.wr_byte = app_byte;
      ctl_o.wr_wild = app_wild;
      len_nxt       = len_r + LEN_W'(1);
      span_nxt      = len_r[IDX_W-1:0];
      if (len_r == LEN_W'(PAT_DEPTH - 1)) begin
        phase_nxt = PH_HALT;
        wait_nxt  = 1'b0;
        status_o  = ST_TOOLONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COLLECT;
      len_r   <= '0;
      span_r  <= '0;
      pend_r  <= 8'h00;
      wait_r  <= 1'b0;
      roff_r  <= '0;
      seen_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      span_r  <= span_nxt;
      pend_r  <= pend_nxt;
      wait_r  <= wait_nxt;
      roff_r  <= roff_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wildcard_signature_scanner.sv -----
// ----------------------------------------------------------------------------
// Wildcard signature scanner
// Parses a hex/wildcard signature, then searches a byte stream for it.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    in_action, in_data, in_region_last
//   out      out  out_valid / out_ready  out_status, out_match_offset
//
// One request per cycle while in_ready is high; every request gives one result in
// the next cycle. All pattern cells compare each region byte at once, so the rate
// is set by the cell row and the single output register.
// in_ready is low only while a result is held and out_ready is low.
// Reset is synchronous; the pattern store needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "wildcard_signature_scanner_defines.svh"

module wildcard_signature_scanner
  import wss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_action,
  input  wire logic [7:0]       in_data,
  input  wire logic             in_region_last,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [2:0]            out_status,
  output logic [OFF_W-1:0]      out_match_offset
);

  logic                 fire;
  cell_ctl_t            ctl;
  logic [IDX_W-1:0]     wr_idx;
  status_t              status;
  logic [OFF_W-1:0]     offset;
  logic [PAT_DEPTH-1:0] pm;
  logic [PAT_DEPTH-1:0] hit;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [OFF_W-1:0]     out_offset_r;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  wss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire_i    (fire),
    .action_i  (in_action),
    .data_i    (in_data),
    .last_i    (in_region_last),
    .any_hit_i (|hit),
    .ctl_o     (ctl),
    .wr_idx_o  (wr_idx),
    .status_o  (status),
    .offset_o  (offset)
  );

  for (genvar i = 0; i < PAT_DEPTH; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_body
      assign prev = pm[i-1];
    end
    wss_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .sel    (wr_idx == IDX_W'(i)),
      .prev_i (prev),
      .pm_o   (pm[i]),
      .hit_o  (hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status;
      out_offset_r <= offset;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_match_offset = out_offset_r;

  `WSS_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)
  `WSS_ASSERT_NEXT(a_clear_quiet, in_valid && in_ready && in_action == ACT_CLEAR,
                   out_status == ST_NONE && out_match_offset == '0)
  `WSS_ASSERT_NOW(a_offset_zero, out_valid && out_status != ST_MATCH,
                  out_match_offset == '0)

endmodule

`default_nettype wire
